// ===== design/u8esc_pkg.sv =====
// ----------------------------------------------------------------------------
// u8esc_pkg
// Shared word types, job descriptor and byte constants for the escaper.
// ----------------------------------------------------------------------------
package u8esc_pkg;

	// input word and result word
	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_string;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
	} result_t;

	// how the fresh byte of a word is written out
	typedef enum logic [2:0] {
		FRESH_NONE,
		FRESH_LIT,
		FRESH_ESC2,
		FRESH_UESC,
		FRESH_REPL
	} fresh_kind_t;

	// output segments of one job, in emission order
	typedef enum logic [2:0] {
		SEG_OPEN,
		SEG_PRE,
		SEG_PASS,
		SEG_FRESH,
		SEG_POST,
		SEG_CLOSE
	} seg_t;

	localparam int unsigned SEG_COUNT = 6;

	// one classified input word, as handed from front to back
	typedef struct packed {
		logic             open;
		logic [1:0]       pre_n;
		logic [2:0]       pass_n;
		logic [3:0][7:0]  pass_bytes;
		fresh_kind_t      fresh_kind;
		logic [7:0]       fresh_byte;
		logic [1:0]       post_n;
		logic             close;
	} job_t;

	// ascii bytes
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DEL    = 8'h7F;
	localparam logic [7:0] CH_ALPHA_BASE = 8'h57;

	// utf-8 lead and continuation bounds
	localparam logic [7:0] ASCII_LIMIT = 8'h80;
	localparam logic [7:0] LEAD_MIN    = 8'hC2;
	localparam logic [7:0] LEAD_3      = 8'hE0;
	localparam logic [7:0] LEAD_4      = 8'hF0;
	localparam logic [7:0] LEAD_LIMIT  = 8'hF5;
	localparam logic [7:0] LEAD_ED     = 8'hED;
	localparam logic [7:0] LEAD_F4     = 8'hF4;
	localparam logic [7:0] CONT_LO     = 8'h80;
	localparam logic [7:0] CONT_HI     = 8'hBF;
	localparam logic [7:0] CONT_E0_LO  = 8'hA0;
	localparam logic [7:0] CONT_ED_HI  = 8'h9F;
	localparam logic [7:0] CONT_F0_LO  = 8'h90;
	localparam logic [7:0] CONT_F4_HI  = 8'h8F;

	// replacement character EF BF BD
	localparam logic [7:0] REPL_B0 = 8'hEF;
	localparam logic [7:0] REPL_B1 = 8'hBF;
	localparam logic [7:0] REPL_B2 = 8'hBD;

	function automatic logic [7:0] repl_byte(input logic [1:0] idx);
		logic [7:0] r;
		case (idx)
			2'd0:    r = REPL_B0;
			2'd1:    r = REPL_B1;
			default: r = REPL_B2;
		endcase
		return r;
	endfunction

	// lowercase hex digit of a nibble
	function automatic logic [7:0] hex_digit(input logic [3:0] nib);
		logic [7:0] r;
		if (nib < 4'd10) begin
			r = CH_ZERO + {4'h0, nib};
		end else begin
			r = CH_ALPHA_BASE + {4'h0, nib};
		end
		return r;
	endfunction

endpackage

// ===== design/u8esc_front.sv =====
// ----------------------------------------------------------------------------
// u8esc_front
// Takes input words, tracks the held utf-8 sequence and the quote state, and
// turns each word into a job descriptor for the back end.
// ----------------------------------------------------------------------------
module u8esc_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  u8esc_pkg::item_t   item,
	output u8esc_pkg::job_t    job,
	output logic               job_valid
);

	logic [7:0] held_q [3];
	logic [1:0] held_cnt_q;
	logic [2:0] exp_len_q;
	logic       quote_q;

	logic [7:0] held_d [3];
	logic [1:0] held_cnt_d;
	logic [2:0] exp_len_d;

	logic [7:0] b;
	logic [7:0] lo;
	logic [7:0] hi;
	logic       fits;
	logic       append;
	logic       complete4;
	logic [2:0] new_cnt;

	assign b = item.in_byte;

	// allowed range for the next continuation byte
	always_comb begin
		lo = u8esc_pkg::CONT_LO;
		hi = u8esc_pkg::CONT_HI;
		if (held_cnt_q == 2'd1) begin
			case (held_q[0])
				u8esc_pkg::LEAD_3:  lo = u8esc_pkg::CONT_E0_LO;
				u8esc_pkg::LEAD_ED: hi = u8esc_pkg::CONT_ED_HI;
				u8esc_pkg::LEAD_4:  lo = u8esc_pkg::CONT_F0_LO;
				u8esc_pkg::LEAD_F4: hi = u8esc_pkg::CONT_F4_HI;
				default: ;
			endcase
		end
		fits = (b >= lo) && (b <= hi);
	end

	assign append    = ((held_cnt_q == 2'd1) || (held_cnt_q == 2'd2)) && fits;
	assign complete4 = (held_cnt_q == 2'd3) && (exp_len_q == 3'd4) && fits;
	assign new_cnt   = {1'b0, held_cnt_q} + 3'd1;

	// classify the word and work out the next held state
	always_comb begin
		job            = '0;
		job.fresh_kind = u8esc_pkg::FRESH_NONE;
		job.open       = !quote_q;
		held_d         = held_q;
		held_cnt_d     = held_cnt_q;
		exp_len_d      = exp_len_q;

		if (append) begin
			if (new_cnt >= exp_len_q) begin
				// sequence complete: pass it through
				job.pass_n        = new_cnt;
				job.pass_bytes[0] = held_q[0];
				job.pass_bytes[1] = (held_cnt_q == 2'd1) ? b : held_q[1];
				job.pass_bytes[2] = b;
				held_cnt_d        = 2'd0;
				exp_len_d         = 3'd0;
			end else begin
				held_d[held_cnt_q] = b;
				held_cnt_d         = new_cnt[1:0];
			end
		end else if (complete4) begin
			job.pass_n        = 3'd4;
			job.pass_bytes[0] = held_q[0];
			job.pass_bytes[1] = held_q[1];
			job.pass_bytes[2] = held_q[2];
			job.pass_bytes[3] = b;
			held_cnt_d        = 2'd0;
			exp_len_d         = 3'd0;
		end else begin
			// broken or no sequence: flush held bytes, then handle b afresh
			job.pre_n      = held_cnt_q;
			job.fresh_byte = b;
			held_cnt_d     = 2'd0;
			exp_len_d      = 3'd0;
			if (b < u8esc_pkg::ASCII_LIMIT) begin
				if ((b == u8esc_pkg::CH_QUOTE) || (b == u8esc_pkg::CH_BSLASH)) begin
					job.fresh_kind = u8esc_pkg::FRESH_ESC2;
				end else if (b == u8esc_pkg::CH_LF) begin
					job.fresh_kind = u8esc_pkg::FRESH_ESC2;
					job.fresh_byte = u8esc_pkg::CH_N;
				end else if (b == u8esc_pkg::CH_CR) begin
					job.fresh_kind = u8esc_pkg::FRESH_ESC2;
					job.fresh_byte = u8esc_pkg::CH_R;
				end else if ((b < u8esc_pkg::CH_SPACE) || (b == u8esc_pkg::CH_DEL)) begin
					job.fresh_kind = u8esc_pkg::FRESH_UESC;
				end else begin
					job.fresh_kind = u8esc_pkg::FRESH_LIT;
				end
			end else if ((b < u8esc_pkg::LEAD_MIN) || (b >= u8esc_pkg::LEAD_LIMIT)) begin
				job.fresh_kind = u8esc_pkg::FRESH_REPL;
			end else begin
				// valid lead: start holding
				held_d[0]  = b;
				held_cnt_d = 2'd1;
				if (b < u8esc_pkg::LEAD_3) begin
					exp_len_d = 3'd2;
				end else if (b < u8esc_pkg::LEAD_4) begin
					exp_len_d = 3'd3;
				end else begin
					exp_len_d = 3'd4;
				end
			end
		end

		// end of string: flush what is still held, then close
		if (item.end_of_string) begin
			job.post_n = held_cnt_d;
			job.close  = 1'b1;
			held_cnt_d = 2'd0;
			exp_len_d  = 3'd0;
		end
	end

	assign job_valid = job.open || (job.pre_n != 2'd0) || (job.pass_n != 3'd0) ||
		(job.fresh_kind != u8esc_pkg::FRESH_NONE) || (job.post_n != 2'd0) || job.close;

	// held state and quote flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cnt_q <= 2'd0;
			exp_len_q  <= 3'd0;
			quote_q    <= 1'b0;
		end else if (take) begin
			held_cnt_q <= held_cnt_d;
			exp_len_q  <= exp_len_d;
			quote_q    <= !item.end_of_string;
		end
	end

	// held bytes, read only while counted
	always_ff @(posedge clk) begin
		if (take) begin
			held_q <= held_d;
		end
	end

endmodule

// ===== design/u8esc_jobq.sv =====
// ----------------------------------------------------------------------------
// u8esc_jobq
// Small first-in first-out queue of job descriptors between front and back.
// ----------------------------------------------------------------------------
module u8esc_jobq #(
	parameter int unsigned DEPTH = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr,
	input  u8esc_pkg::job_t   wdata,
	input  logic              rd,
	output u8esc_pkg::job_t   rdata,
	output logic              full,
	output logic              empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	u8esc_pkg::job_t  slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	logic do_wr;
	logic do_rd;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = slot_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// slot storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// ===== design/u8esc_back.sv =====
// ----------------------------------------------------------------------------
// u8esc_back
// Walks one job descriptor segment by segment, one output byte per cycle
// while the result word is free or being popped, into a single result register.
// ----------------------------------------------------------------------------
module u8esc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  u8esc_pkg::job_t     job,
	input  logic                job_empty,
	output logic                job_rd,
	output u8esc_pkg::result_t  result,
	output logic                empty,
	input  logic                pop
);

	localparam int unsigned SC = u8esc_pkg::SEG_COUNT;

	u8esc_pkg::job_t    job_q;
	logic [SC-1:0]      mask_q;
	logic [3:0]         sub_q;
	logic [1:0]         tri_q;
	logic               out_valid_q;
	u8esc_pkg::result_t result_q;

	logic [SC-1:0]      seg_bit;
	logic [SC-1:0]      mask_after;
	logic [SC-1:0]      job_mask;
	u8esc_pkg::seg_t    seg;
	logic [3:0]         seg_len;
	logic [7:0]         cur_byte;
	logic               emit;
	logic               seg_end;
	logic               load;

	// lowest pending segment
	assign seg_bit = mask_q & (~mask_q + 1'b1);

	always_comb begin
		case (seg_bit)
			6'b000001: seg = u8esc_pkg::SEG_OPEN;
			6'b000010: seg = u8esc_pkg::SEG_PRE;
			6'b000100: seg = u8esc_pkg::SEG_PASS;
			6'b001000: seg = u8esc_pkg::SEG_FRESH;
			6'b010000: seg = u8esc_pkg::SEG_POST;
			default:   seg = u8esc_pkg::SEG_CLOSE;
		endcase
	end

	// length and current byte of the segment
	always_comb begin
		seg_len  = 4'd1;
		cur_byte = u8esc_pkg::CH_QUOTE;
		case (seg)
			u8esc_pkg::SEG_OPEN: begin
				seg_len  = 4'd1;
				cur_byte = u8esc_pkg::CH_QUOTE;
			end
			u8esc_pkg::SEG_PRE: begin
				seg_len  = {2'b00, job_q.pre_n} + {1'b0, job_q.pre_n, 1'b0};
				cur_byte = u8esc_pkg::repl_byte(tri_q);
			end
			u8esc_pkg::SEG_PASS: begin
				seg_len  = {1'b0, job_q.pass_n};
				cur_byte = job_q.pass_bytes[sub_q[1:0]];
			end
			u8esc_pkg::SEG_FRESH: begin
				case (job_q.fresh_kind)
					u8esc_pkg::FRESH_ESC2: begin
						seg_len  = 4'd2;
						cur_byte = (sub_q == 4'd0) ? u8esc_pkg::CH_BSLASH : job_q.fresh_byte;
					end
					u8esc_pkg::FRESH_UESC: begin
						seg_len = 4'd6;
						case (sub_q)
							4'd0:    cur_byte = u8esc_pkg::CH_BSLASH;
							4'd1:    cur_byte = u8esc_pkg::CH_U;
							4'd2:    cur_byte = u8esc_pkg::CH_ZERO;
							4'd3:    cur_byte = u8esc_pkg::CH_ZERO;
							4'd4:    cur_byte = u8esc_pkg::hex_digit(job_q.fresh_byte[7:4]);
							default: cur_byte = u8esc_pkg::hex_digit(job_q.fresh_byte[3:0]);
						endcase
					end
					u8esc_pkg::FRESH_REPL: begin
						seg_len  = 4'd3;
						cur_byte = u8esc_pkg::repl_byte(sub_q[1:0]);
					end
					default: begin
						seg_len  = 4'd1;
						cur_byte = job_q.fresh_byte;
					end
				endcase
			end
			u8esc_pkg::SEG_POST: begin
				seg_len  = {2'b00, job_q.post_n} + {1'b0, job_q.post_n, 1'b0};
				cur_byte = u8esc_pkg::repl_byte(tri_q);
			end
			default: begin
				seg_len  = 4'd1;
				cur_byte = u8esc_pkg::CH_QUOTE;
			end
		endcase
	end

	// segments a fresh job needs
	assign job_mask = {job.close, (job.post_n != 2'd0),
		(job.fresh_kind != u8esc_pkg::FRESH_NONE), (job.pass_n != 3'd0),
		(job.pre_n != 2'd0), job.open};

	assign emit       = (mask_q != '0) && (!out_valid_q || pop);
	assign seg_end    = (sub_q == seg_len - 4'd1);
	assign mask_after = seg_end ? (mask_q & ~seg_bit) : mask_q;
	assign load       = !job_empty && ((mask_q == '0) || (emit && seg_end && (mask_after == '0)));
	assign job_rd     = load;

	// segment walker
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
			sub_q  <= 4'd0;
			tri_q  <= 2'd0;
		end else if (load) begin
			mask_q <= job_mask;
			sub_q  <= 4'd0;
			tri_q  <= 2'd0;
		end else if (emit) begin
			mask_q <= mask_after;
			if (seg_end) begin
				sub_q <= 4'd0;
				tri_q <= 2'd0;
			end else begin
				sub_q <= sub_q + 4'd1;
				tri_q <= (tri_q == 2'd2) ? 2'd0 : tri_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			job_q <= job;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			result_q.out_byte <= cur_byte;
			result_q.out_last <= (seg == u8esc_pkg::SEG_CLOSE);
		end
	end

	assign result = result_q;
	assign empty  = !out_valid_q;

endmodule

// ===== design/utf8_sanitizing_string_escaper.sv =====
// ----------------------------------------------------------------------------
// utf8_sanitizing_string_escaper
// Quoted, escaped copy of a byte string with utf-8 sequences checked.
//
//   channel   direction  handshake          word
//   input     in         push / full        item   (in_byte, end_of_string)
//   result    out        empty / pop        result (out_byte, out_last)
//
// The front takes one word per cycle while the job queue has room; each word
// that releases output becomes one job, a word that only extends a held
// sequence makes none. The back writes one result word per cycle while the
// result register is free or popped; a job holds 1 to 17 bytes, and plain text
// runs at one word per cycle end to end. A full job queue raises full, an
// unread result register stalls the back. Reset clears all control state at
// once; there is no clearing pass.
// ----------------------------------------------------------------------------
module utf8_sanitizing_string_escaper #(
	parameter int unsigned JOB_DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  u8esc_pkg::item_t    item,
	output logic                empty,
	input  logic                pop,
	output u8esc_pkg::result_t  result
);

	u8esc_pkg::job_t front_job;
	u8esc_pkg::job_t queue_job;
	logic            front_job_valid;
	logic            take;
	logic            queue_empty;
	logic            queue_rd;

	assign take = push && !full;

	// classify and track sequence state
	u8esc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.item      (item),
		.job       (front_job),
		.job_valid (front_job_valid)
	);

	// job queue
	u8esc_jobq #(
		.DEPTH (JOB_DEPTH)
	) u_jobq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (take && front_job_valid),
		.wdata  (front_job),
		.rd     (queue_rd),
		.rdata  (queue_job),
		.full   (full),
		.empty  (queue_empty)
	);

	// expand jobs into result bytes
	u8esc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (queue_job),
		.job_empty (queue_empty),
		.job_rd    (queue_rd),
		.result    (result),
		.empty     (empty),
		.pop       (pop)
	);

endmodule

// ===== design/u8esc_checker.sv =====
// ----------------------------------------------------------------------------
// u8esc_checker
// Port-level checks on the escaper, attached to the top level by bind.
// ----------------------------------------------------------------------------
module u8esc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               full,
	input logic               empty,
	input logic               pop,
	input u8esc_pkg::result_t result
);

	logic expect_open_q;
	logic out_take;

	assign out_take = pop && !empty;

	// next result word opens a string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_open_q <= 1'b1;
		end else if (out_take) begin
			expect_open_q <= result.out_last;
		end
	end

	// result register is empty while in reset
	a_reset_empty: assert property (@(posedge clk) !arst_n |=> empty)
		else $error("result shown during reset");

	// input side is open while in reset
	a_reset_full: assert property (@(posedge clk) !arst_n |=> !full)
		else $error("full raised during reset");

	// a waiting result word stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("waiting result word changed");

	// each string starts with an opening quote
	a_open: assert property (@(posedge clk) disable iff (!arst_n)
		(out_take && expect_open_q) |->
		(result.out_byte == u8esc_pkg::CH_QUOTE && !result.out_last))
		else $error("string did not open with a quote");

	// end of string is always a quote
	a_close: assert property (@(posedge clk) disable iff (!arst_n)
		(out_take && result.out_last) |-> (result.out_byte == u8esc_pkg::CH_QUOTE))
		else $error("last word is not a quote");

endmodule

bind utf8_sanitizing_string_escaper u8esc_checker u_u8esc_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.full   (full),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);

// ===== tb/sv/utf8_sanitizing_string_escaper_tb.sv =====
// ----------------------------------------------------------------------------
// utf8_sanitizing_string_escaper_tb
// Self-checking bench for the quoting and escaping unit with utf-8 checks.
// A directed string set covers escapes, control bytes, valid and broken
// sequences and end-of-string flushes. Random strings follow, mostly built
// from well-formed utf-8 units with noise mixed in. Every accepted input
// word is run through a model of the escaper. Every result word popped from
// the block is compared with the oldest predicted byte. Both sides idle in
// short random bursts. The result side holds off once for a long stretch,
// and the input side waits for a full drain once mid-run and at the end.
// ----------------------------------------------------------------------------
module utf8_sanitizing_string_escaper_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD   = 10;
	localparam int RESET_CYCLES = 5;
	localparam int RANDOM_WORDS = 445;
	localparam int RX_HOLD_LEN  = 300;
	localparam int CALM_TAIL    = 60;
	localparam int DRAIN_CYCLES = 40;
	localparam int TIMEOUT_NS   = 5_000_000;
	localparam logic [7:0] CH_LOWER_A = 8'h61;

	// model of the escaper and the bytes it still expects
	class escape_checker;
		u8esc_pkg::result_t escaped_q[$];
		logic [7:0] held[3];
		logic [1:0] held_cnt;
		logic [2:0] seq_len;
		bit         quote_open;
		int         errors;

		function new();
			held_cnt   = '0;
			seq_len    = '0;
			quote_open = 1'b0;
			errors     = 0;
			foreach (held[i]) held[i] = '0;
		endfunction

		function int pending();
			return escaped_q.size();
		endfunction

		function void put(logic [7:0] b, logic last);
			u8esc_pkg::result_t r;
			r.out_byte = b;
			r.out_last = last;
			escaped_q.push_back(r);
		endfunction

		function void put_repl();
			put(u8esc_pkg::REPL_B0, 1'b0);
			put(u8esc_pkg::REPL_B1, 1'b0);
			put(u8esc_pkg::REPL_B2, 1'b0);
		endfunction

		function void flush_held();
			repeat (held_cnt) put_repl();
			held_cnt = '0;
			seq_len  = '0;
		endfunction

		function logic [7:0] hex_of(logic [3:0] nib);
			if (nib < 4'd10)
				return u8esc_pkg::CH_ZERO + 8'(nib);
			return CH_LOWER_A + 8'(nib) - 8'd10;
		endfunction

		// continuation range for a position of the held sequence
		function bit fits(logic [7:0] b, logic [1:0] pos);
			logic [7:0] lo;
			logic [7:0] hi;
			lo = u8esc_pkg::CONT_LO;
			hi = u8esc_pkg::CONT_HI;
			if (pos == 2'd1) begin
				if (held[0] == u8esc_pkg::LEAD_3)
					lo = u8esc_pkg::CONT_E0_LO;
				else if (held[0] == u8esc_pkg::LEAD_ED)
					hi = u8esc_pkg::CONT_ED_HI;
				else if (held[0] == u8esc_pkg::LEAD_4)
					lo = u8esc_pkg::CONT_F0_LO;
				else if (held[0] == u8esc_pkg::LEAD_F4)
					hi = u8esc_pkg::CONT_F4_HI;
			end
			return (b >= lo) && (b <= hi);
		endfunction

		// a byte seen with nothing held
		function void escape_fresh(logic [7:0] b);
			if (b < u8esc_pkg::ASCII_LIMIT) begin
				if (b == u8esc_pkg::CH_QUOTE || b == u8esc_pkg::CH_BSLASH) begin
					put(u8esc_pkg::CH_BSLASH, 1'b0);
					put(b, 1'b0);
				end else if (b == u8esc_pkg::CH_LF) begin
					put(u8esc_pkg::CH_BSLASH, 1'b0);
					put(u8esc_pkg::CH_N, 1'b0);
				end else if (b == u8esc_pkg::CH_CR) begin
					put(u8esc_pkg::CH_BSLASH, 1'b0);
					put(u8esc_pkg::CH_R, 1'b0);
				end else if (b < u8esc_pkg::CH_SPACE || b == u8esc_pkg::CH_DEL) begin
					put(u8esc_pkg::CH_BSLASH, 1'b0);
					put(u8esc_pkg::CH_U, 1'b0);
					put(u8esc_pkg::CH_ZERO, 1'b0);
					put(u8esc_pkg::CH_ZERO, 1'b0);
					put(hex_of(b[7:4]), 1'b0);
					put(hex_of(b[3:0]), 1'b0);
				end else begin
					put(b, 1'b0);
				end
			end else if (b < u8esc_pkg::LEAD_MIN || b >= u8esc_pkg::LEAD_LIMIT) begin
				put_repl();
			end else begin
				held[0]  = b;
				held_cnt = 2'd1;
				seq_len  = (b < u8esc_pkg::LEAD_3) ? 3'd2 :
					(b < u8esc_pkg::LEAD_4) ? 3'd3 : 3'd4;
			end
		endfunction

		// accepted input word: predict every byte it releases
		function void take_byte(u8esc_pkg::item_t w);
			logic [7:0] b;
			b = w.in_byte;
			if (!quote_open) begin
				put(u8esc_pkg::CH_QUOTE, 1'b0);
				quote_open = 1'b1;
			end
			if (held_cnt > 0 && held_cnt < 3 && fits(b, held_cnt)) begin
				held[held_cnt] = b;
				held_cnt = held_cnt + 2'd1;
				if (3'(held_cnt) >= seq_len) begin
					for (int i = 0; i < held_cnt; i++) put(held[i], 1'b0);
					held_cnt = '0;
					seq_len  = '0;
				end
			end else if (held_cnt == 3 && seq_len == 4 && fits(b, 2'd3)) begin
				for (int i = 0; i < 3; i++) put(held[i], 1'b0);
				put(b, 1'b0);
				held_cnt = '0;
				seq_len  = '0;
			end else begin
				if (held_cnt > 0)
					flush_held();
				escape_fresh(b);
			end
			if (w.end_of_string) begin
				flush_held();
				put(u8esc_pkg::CH_QUOTE, 1'b1);
				quote_open = 1'b0;
			end
		endfunction

		function void report(string msg);
			errors++;
			$error("%s", msg);
		endfunction

		// popped result word against the oldest prediction
		function void match_output(u8esc_pkg::result_t got);
			u8esc_pkg::result_t want;
			if (escaped_q.size() == 0) begin
				report($sformatf("unexpected word: out_byte %02h out_last %0b",
					got.out_byte, got.out_last));
				return;
			end
			want = escaped_q.pop_front();
			if (got.out_byte !== want.out_byte)
				report($sformatf("out_byte mismatch: expected %02h, actual %02h",
					want.out_byte, got.out_byte));
			if (got.out_last !== want.out_last)
				report($sformatf("out_last mismatch: expected %0b, actual %0b",
					want.out_last, got.out_last));
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               push;
	logic               full;
	u8esc_pkg::item_t   item;
	logic               empty;
	logic               pop;
	u8esc_pkg::result_t result;

	escape_checker      chk;
	u8esc_pkg::item_t   stim_q[$];
	logic [7:0]         str_q[$];
	bit                 calm;
	bit                 rx_hold_req;

	always #(CLK_PERIOD / 2) clk = ~clk;

	utf8_sanitizing_string_escaper u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	// watch both handshakes
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty)
				chk.match_output(result);
			if (push && !full)
				chk.take_byte(item);
		end
	end

	// result side: random pop bursts, one long hold-off on request
	initial begin
		pop = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (rx_hold_req) begin
				pop <= 1'b0;
				repeat (RX_HOLD_LEN) @(posedge clk);
				rx_hold_req = 1'b0;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end else begin
				pop <= 1'b1;
				@(posedge clk);
			end
		end
	end

	function automatic u8esc_pkg::item_t mk(logic [7:0] b, logic eos);
		u8esc_pkg::item_t w;
		w.in_byte       = b;
		w.end_of_string = eos;
		return w;
	endfunction

	function automatic logic [7:0] cont_any();
		return 8'($urandom_range(u8esc_pkg::CONT_HI, u8esc_pkg::CONT_LO));
	endfunction

	// first continuation byte, narrowed by the lead
	function automatic logic [7:0] cont_after(logic [7:0] lead);
		logic [7:0] lo;
		logic [7:0] hi;
		lo = u8esc_pkg::CONT_LO;
		hi = u8esc_pkg::CONT_HI;
		if (lead == u8esc_pkg::LEAD_3)
			lo = u8esc_pkg::CONT_E0_LO;
		else if (lead == u8esc_pkg::LEAD_ED)
			hi = u8esc_pkg::CONT_ED_HI;
		else if (lead == u8esc_pkg::LEAD_4)
			lo = u8esc_pkg::CONT_F0_LO;
		else if (lead == u8esc_pkg::LEAD_F4)
			hi = u8esc_pkg::CONT_F4_HI;
		return 8'($urandom_range(hi, lo));
	endfunction

	// one well-formed sequence of two, three or four bytes
	task automatic add_valid_seq();
		logic [7:0] lead;
		case ($urandom_range(0, 2))
			0: begin
				lead = 8'($urandom_range(8'hDF, u8esc_pkg::LEAD_MIN));
				str_q.push_back(lead);
				str_q.push_back(cont_any());
			end
			1: begin
				if ($urandom_range(0, 2) == 0)
					lead = $urandom_range(0, 1) ? u8esc_pkg::LEAD_3 : u8esc_pkg::LEAD_ED;
				else
					lead = 8'($urandom_range(8'hEF, u8esc_pkg::LEAD_3));
				str_q.push_back(lead);
				str_q.push_back(cont_after(lead));
				str_q.push_back(cont_any());
			end
			default: begin
				if ($urandom_range(0, 2) == 0)
					lead = $urandom_range(0, 1) ? u8esc_pkg::LEAD_4 : u8esc_pkg::LEAD_F4;
				else
					lead = 8'($urandom_range(u8esc_pkg::LEAD_F4, u8esc_pkg::LEAD_4));
				str_q.push_back(lead);
				str_q.push_back(cont_after(lead));
				str_q.push_back(cont_any());
				str_q.push_back(cont_any());
			end
		endcase
	endtask

	// one unit of text: plain, escaped, control, utf-8 or noise
	task automatic add_unit();
		int r;
		int n0;
		int keep;
		r = $urandom_range(0, 99);
		if (r < 35) begin
			str_q.push_back(8'($urandom_range(8'h7E, u8esc_pkg::CH_SPACE)));
		end else if (r < 45) begin
			case ($urandom_range(0, 3))
				0: str_q.push_back(u8esc_pkg::CH_QUOTE);
				1: str_q.push_back(u8esc_pkg::CH_BSLASH);
				2: str_q.push_back(u8esc_pkg::CH_LF);
				default: str_q.push_back(u8esc_pkg::CH_CR);
			endcase
		end else if (r < 55) begin
			if ($urandom_range(0, 4) == 0)
				str_q.push_back(u8esc_pkg::CH_DEL);
			else
				str_q.push_back(8'($urandom_range(8'h1F, 0)));
		end else if (r < 85) begin
			add_valid_seq();
		end else if (r < 95) begin
			// truncated sequence, maybe followed by a breaking byte
			n0 = str_q.size();
			add_valid_seq();
			keep = $urandom_range(str_q.size() - n0 - 1, 1);
			while (str_q.size() > n0 + keep) void'(str_q.pop_back());
			if ($urandom_range(0, 1)) begin
				if ($urandom_range(0, 1))
					str_q.push_back(8'($urandom_range(255, 0)));
				else
					str_q.push_back(8'($urandom_range(8'hC0, 8'h7F)));
			end
		end else begin
			str_q.push_back(8'($urandom_range(255, 8'h80)));
		end
	endtask

	task automatic build_random_text(int target);
		while (stim_q.size() < target) begin
			str_q.delete();
			repeat ($urandom_range(1, 10)) add_unit();
			foreach (str_q[i]) stim_q.push_back(mk(str_q[i], i == str_q.size() - 1));
		end
	endtask

	task automatic build_directed();
		// escapes, control bytes and plain ascii, one string
		stim_q.push_back(mk(8'h00, 1'b0));
		stim_q.push_back(mk(u8esc_pkg::CH_QUOTE, 1'b0));
		stim_q.push_back(mk(u8esc_pkg::CH_BSLASH, 1'b0));
		stim_q.push_back(mk(u8esc_pkg::CH_LF, 1'b0));
		stim_q.push_back(mk(u8esc_pkg::CH_CR, 1'b0));
		stim_q.push_back(mk(u8esc_pkg::CH_DEL, 1'b0));
		stim_q.push_back(mk(u8esc_pkg::CH_SPACE, 1'b0));
		stim_q.push_back(mk(8'h7E, 1'b1));
		// valid two- and four-byte sequences, the four-byte one at the top of its range
		stim_q.push_back(mk(8'hC3, 1'b0));
		stim_q.push_back(mk(8'hA9, 1'b0));
		stim_q.push_back(mk(u8esc_pkg::LEAD_F4, 1'b0));
		stim_q.push_back(mk(u8esc_pkg::CONT_F4_HI, 1'b0));
		stim_q.push_back(mk(u8esc_pkg::CONT_HI, 1'b0));
		stim_q.push_back(mk(u8esc_pkg::CONT_HI, 1'b0));
		// stray continuation, overlong lead, lead out of range
		stim_q.push_back(mk(u8esc_pkg::CONT_LO, 1'b0));
		stim_q.push_back(mk(8'hC1, 1'b0));
		stim_q.push_back(mk(8'hFF, 1'b0));
		// broken sequences: narrowed second byte, then after two held
		stim_q.push_back(mk(u8esc_pkg::LEAD_3, 1'b0));
		stim_q.push_back(mk(u8esc_pkg::CONT_ED_HI, 1'b0));
		stim_q.push_back(mk(u8esc_pkg::LEAD_ED, 1'b0));
		stim_q.push_back(mk(u8esc_pkg::CONT_E0_LO, 1'b0));
		stim_q.push_back(mk(u8esc_pkg::LEAD_4, 1'b0));
		stim_q.push_back(mk(u8esc_pkg::CONT_F0_LO, 1'b0));
		stim_q.push_back(mk(8'h41, 1'b0));
		// end of string with a lead still held
		stim_q.push_back(mk(8'hE2, 1'b1));
	endtask

	// offer one word, optionally after a short gap
	task automatic send_word(u8esc_pkg::item_t w);
		if (!calm && $urandom_range(0, 7) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		push <= 1'b1;
		item <= w;
		do @(posedge clk); while (full);
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		@(posedge clk);
		while (chk.pending() != 0) @(posedge clk);
	endtask

	// main sequence
	initial begin
		int hold_at;
		int pause_at;
		int calm_from;
		chk         = new();
		arst_n      = 1'b0;
		push        = 1'b0;
		item        = '0;
		calm        = 1'b0;
		rx_hold_req = 1'b0;

		build_directed();
		build_random_text(stim_q.size() + RANDOM_WORDS);
		hold_at   = stim_q.size() / 3;
		pause_at  = (2 * stim_q.size()) / 3;
		calm_from = stim_q.size() - CALM_TAIL;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_q[i]) begin
			if (i == hold_at)
				rx_hold_req = 1'b1;
			if (i == pause_at)
				wait_drained();
			if (i == calm_from)
				calm = 1'b1;
			send_word(stim_q[i]);
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (chk.pending() != 0)
			chk.report($sformatf("%0d expected words never arrived", chk.pending()));

		if (chk.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// hang guard
	initial begin
		#(TIMEOUT_NS);
		$display("Verification failed");
		$finish;
	end

endmodule
